FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked on every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked on every edge, reset included
`define ASSERT_ANY_EDGE(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_ANY_EDGE(label, clk, prop, msg)
`endif

`endif

FILE: sv/mdf_pkg.sv
// ----------------------------------------------------------------------------
// mdf_pkg
// Shared types and constants of the PUBLISH deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package mdf_pkg;

  localparam int CMD_SLOTS   = 8;
  localparam int CMD_BYTES   = 512;
  localparam int SLOT_W      = (CMD_SLOTS > 1) ? $clog2(CMD_SLOTS) : 1;
  localparam int LEN_W       = 28;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [LEN_W-1:0] TRUNC_OFF = LEN_W'(CMD_BYTES - 3);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_VARINT = 2'd1;
  localparam logic [1:0] ST_TOPIC  = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       start_of_record;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             has_byte;
    logic             first_of_message;
    logic             last_of_message;
    logic [LEN_W-1:0] message_length;
    logic [LEN_W-1:0] byte_offset;
    logic [2:0]       slot_index;
    logic             truncated;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    logic push;
    out_t item;
  } q_wr_t;

endpackage

`default_nettype wire

FILE: sv/mqtt_publish_deframer.sv
// ----------------------------------------------------------------------------
// mqtt_publish_deframer
// QoS-0 PUBLISH deframer: stream bytes in, tagged payload bytes out.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle, sustained, as long as the result side
// keeps up. Each byte updates the parser phase (header, length varint,
// topic length, topic, payload); a payload byte, an empty payload marker
// or an error yields one result transaction, which is written into the
// queue and then registered onto the result port. A four-entry queue plus
// the output register absorb result-side stalls; item_ready drops only when
// the queue is full. No startup sweep: the block is ready right after reset.
`default_nettype none
`include "assert_macros.svh"

module mqtt_publish_deframer import mdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  in_t  item,
  input  logic item_valid,
  output logic item_ready,
  output out_t result,
  output logic result_valid,
  input  logic result_ready
);

  q_wr_t q_wr;
  logic  q_full, take, head_valid, pop;
  out_t  head;

  assign item_ready = !q_full;
  assign take       = item_valid && item_ready;

  mdf_front u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .take (take),
    .wr   (q_wr)
  );

  mdf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (q_wr),
    .full       (q_full),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  mdf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  `ASSERT_ALWAYS(a_no_overflow, clk, rst, q_wr.push |-> !q_full, "queue push while full")
  `ASSERT_ALWAYS(a_marker_ends, clk, rst, result_valid && !result.has_byte |-> result.first_of_message && result.last_of_message, "marker not both first and last")
  `ASSERT_ALWAYS(a_error_no_byte, clk, rst, result_valid && (result.status != ST_OK) |-> !result.has_byte, "error result carries a byte")
  `ASSERT_ANY_EDGE(a_reset_idle, clk, rst |=> !result_valid, "result valid right after reset")

endmodule

`default_nettype wire

FILE: sv/mdf_front.sv
// ----------------------------------------------------------------------------
// mdf_front
// Parser: tracks the phase; one result per payload byte, empty payload, error.
// ----------------------------------------------------------------------------
`default_nettype none

module mdf_front import mdf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  in_t   item,
  input  logic  take,
  output q_wr_t wr
);

  typedef enum logic [2:0] {
    PH_HDR, PH_LEN, PH_TLEN_HI, PH_TLEN_LO, PH_TOPIC, PH_PAYLOAD, PH_SKIP, PH_DROP
  } phase_t;

  phase_t            phase, phase_next;
  logic [LEN_W-1:0]  rem_len, rem_len_next;
  logic [1:0]        vpos, vpos_next;
  logic [15:0]       topic_left, topic_left_next;
  logic [LEN_W-1:0]  pay_len, pay_len_next;
  logic [LEN_W-1:0]  pay_off, pay_off_next;
  logic [SLOT_W-1:0] slot, slot_next, slot_inc;

  logic [7:0]        b;
  logic [LEN_W-1:0]  rem_dec, rem_m1, var_add, var_sum, topic_rl;
  logic [15:0]       topic_lo, topic_dec;
  logic [LEN_W:0]    off_p1;
  logic              pay_last, topic_end, emit;
  out_t              res;

  assign b        = item.rx_byte;
  assign rem_dec  = (rem_len != '0) ? rem_len - LEN_W'(1) : rem_len;
  assign rem_m1   = rem_len - LEN_W'(1);
  assign topic_lo = {topic_left[15:8], b};
  assign topic_dec = (topic_left != '0) ? topic_left - 16'd1 : topic_left;
  assign off_p1   = {1'b0, pay_off} + (LEN_W+1)'(1);
  assign pay_last = off_p1 >= {1'b0, pay_len};
  assign slot_inc = (slot == SLOT_W'(CMD_SLOTS - 1)) ? '0 : slot + SLOT_W'(1);
  assign var_sum  = rem_len + var_add;

  // 7-bit group placed at its base-128 position
  always_comb begin
    case (vpos)
      2'd0:    var_add = {21'b0, b[6:0]};
      2'd1:    var_add = {14'b0, b[6:0], 7'b0};
      2'd2:    var_add = {7'b0, b[6:0], 14'b0};
      default: var_add = {b[6:0], 21'b0};
    endcase
  end

  always_comb begin
    phase_next      = phase;
    rem_len_next    = rem_len;
    vpos_next       = vpos;
    topic_left_next = topic_left;
    pay_len_next    = pay_len;
    pay_off_next    = pay_off;
    slot_next       = slot;
    topic_end       = 1'b0;
    topic_rl        = rem_len;
    emit            = 1'b0;
    res             = '0;
    res.slot_index  = 3'(slot);
    res.first_of_message = 1'b1;
    res.last_of_message  = 1'b1;

    if (item.start_of_record || phase == PH_HDR) begin
      phase_next   = PH_LEN;
      rem_len_next = '0;
      vpos_next    = '0;
    end else begin
      unique case (phase)
        PH_LEN: begin
          rem_len_next = var_sum;
          if (b[7]) begin
            if (vpos == 2'd3) begin
              phase_next = PH_DROP;
              emit       = 1'b1;
              res.status = ST_VARINT;
            end else begin
              vpos_next = vpos + 2'd1;
            end
          end else if (var_sum < LEN_W'(2)) begin
            phase_next = (var_sum == '0) ? PH_HDR : PH_SKIP;
            emit       = 1'b1;
            res.status = ST_TOPIC;
          end else begin
            phase_next = PH_TLEN_HI;
          end
        end
        PH_TLEN_HI: begin
          topic_left_next = {b, 8'b0};
          rem_len_next    = rem_m1;
          phase_next      = PH_TLEN_LO;
        end
        PH_TLEN_LO: begin
          topic_left_next = topic_lo;
          rem_len_next    = rem_m1;
          if (LEN_W'(topic_lo) > rem_m1) begin
            phase_next = (rem_m1 == '0) ? PH_HDR : PH_SKIP;
            emit       = 1'b1;
            res.status = ST_TOPIC;
          end else if (topic_lo == '0) begin
            topic_end = 1'b1;
            topic_rl  = rem_m1;
          end else begin
            phase_next = PH_TOPIC;
          end
        end
        PH_TOPIC: begin
          topic_left_next = topic_dec;
          rem_len_next    = rem_dec;
          if (topic_dec == '0) begin
            topic_end = 1'b1;
            topic_rl  = rem_dec;
          end
        end
        PH_PAYLOAD: begin
          emit                 = 1'b1;
          res.out_byte         = b;
          res.has_byte         = 1'b1;
          res.first_of_message = (pay_off == '0);
          res.last_of_message  = pay_last;
          res.message_length   = pay_len;
          res.byte_offset      = pay_off;
          res.truncated        = (pay_off >= TRUNC_OFF);
          rem_len_next         = rem_dec;
          if (pay_last) begin
            slot_next    = slot_inc;
            phase_next   = PH_HDR;
            pay_off_next = '0;
          end else begin
            pay_off_next = off_p1[LEN_W-1:0];
          end
        end
        PH_SKIP: begin
          rem_len_next = rem_dec;
          if (rem_dec == '0) phase_next = PH_HDR;
        end
        PH_HDR, PH_DROP: begin
        end
      endcase

      // topic consumed: open the payload, or mark an empty one
      if (topic_end) begin
        pay_len_next = topic_rl;
        pay_off_next = '0;
        if (topic_rl == '0) begin
          emit       = 1'b1;
          slot_next  = slot_inc;
          phase_next = PH_HDR;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end
  end

  assign wr.push = take && emit;
  assign wr.item = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR;
      rem_len    <= '0;
      vpos       <= '0;
      topic_left <= '0;
      pay_len    <= '0;
      pay_off    <= '0;
      slot       <= '0;
    end else if (take) begin
      phase      <= phase_next;
      rem_len    <= rem_len_next;
      vpos       <= vpos_next;
      topic_left <= topic_left_next;
      pay_len    <= pay_len_next;
      pay_off    <= pay_off_next;
      slot       <= slot_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/mdf_queue.sv
// ----------------------------------------------------------------------------
// mdf_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mdf_queue import mdf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  q_wr_t wr,
  output logic  full,
  output out_t  head,
  output logic  head_valid,
  input  logic  pop
);

  out_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_pop;

  assign full       = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (wr.push) mem[wr_ptr] <= wr.item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({wr.push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/mdf_back.sv
// ----------------------------------------------------------------------------
// mdf_back
// Output register: drains the queue onto the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mdf_back import mdf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  out_t head,
  input  logic head_valid,
  output logic pop,
  output out_t result,
  output logic result_valid,
  input  logic result_ready
);

  assign pop = head_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) result <= head;
  end

endmodule

`default_nettype wire
